// ===== hw/rtl/dwc_pkg.sv =====
// Shared types, constants and index helpers for the deque-with-cursor block.
// No dependencies; every other file in hw/rtl except dwc_ram imports this package.
package dwc_pkg;

  // Store geometry and field widths
  localparam int unsigned DEPTH     = 64;
  localparam int unsigned ITEM_W    = 32;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned RESULT_W  = 32;

  // Stream word widths, padded to whole bytes; kind and item_valid travel in tuser
  localparam int unsigned S_TDATA_RAW = ITEM_W;
  localparam int unsigned S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
  localparam int unsigned M_TDATA_RAW = RESULT_W + CNT_W + 1;
  localparam int unsigned M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ITEM_W-1:0]   item_t;
  typedef logic [RESULT_W-1:0] result_t;

  // Operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_POP_BACK   = 4'd1,
    OP_PUSH_FRONT = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_START      = 4'd4,
    OP_NEXT       = 4'd5,
    OP_END        = 4'd6,
    OP_CURRENT    = 4'd7,
    OP_FIRST      = 4'd8,
    OP_LAST       = 4'd9
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // take the input word, update state, start slot access
    logic load;    // move the finished result into the output register
  } dwc_cmd_t;

  // Ring index plus an offset below DEPTH, wrapped with one compare-subtract
  function automatic idx_t ring_add(idx_t a, cnt_t b);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Step a ring index back by one
  function automatic idx_t ring_dec(idx_t a);
    idx_t r;
    if (a == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = a - 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/deque_with_cursor_unit.sv =====
// Channel | Dir | Signals                         | Word contents (low bit first)
// s_axis  | in  | tvalid, tready, tuser[3:0],     | tuser: kind[3:0]
//         |     | tdata[31:0]                     | tdata: item[31:0]
// m_axis  | out | tvalid, tready, tuser,          | tuser: item_valid
//         |     | tdata[39:0]                     | tdata: result_item[31:0],
//         |     |                                 | entry_count[38:32], push_dropped[39]
//
// Each operation has an accept step and a read step: the accept cycle updates head,
// count and cursor and issues the slot write or read; the read step takes the
// registered slot RAM read into the output register. A new word is accepted while
// a finished result still waits on m_axis; it then holds in the read stage until
// the output register frees. Reset clears head, count and cursor at once; the
// slot store is not cleared, since only written slots are ever read.
//
// Top level of the deque-with-cursor block; depends on dwc_pkg, dwc_ctrl, dwc_dp.
module deque_with_cursor_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // kind[3:0]
  input  logic [dwc_pkg::KIND_W-1:0]     s_axis_tuser,
  // item[31:0]
  input  logic [dwc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // item_valid
  output logic                           m_axis_tuser,
  // result_item[31:0], entry_count[38:32], push_dropped[39]
  output logic [dwc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import dwc_pkg::*;

  dwc_cmd_t cmd;
  result_t  result_item;
  logic     item_valid;
  cnt_t     entry_count;
  logic     push_dropped;

  dwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  dwc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (s_axis_tuser),
    .item_i         (s_axis_tdata[ITEM_W-1:0]),
    .result_item_o  (result_item),
    .item_valid_o   (item_valid),
    .entry_count_o  (entry_count),
    .push_dropped_o (push_dropped)
  );

  // Pack the result word and its side flag
  assign m_axis_tdata = {push_dropped, entry_count, result_item};
  assign m_axis_tuser = item_valid;

  // One word in flight: no accept in the cycle right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous word still in the read stage");

  // Count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (entry_count <= CNT_W'(DEPTH)))
    else $error("entry count above depth");

  // A null result carries a zero item
  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !item_valid) |-> (result_item == '0))
    else $error("null result with nonzero item");

  // A dropped push only happens on a full store
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && push_dropped) |-> (entry_count == CNT_W'(DEPTH) && !item_valid))
    else $error("push dropped while store not full");

endmodule

// ===== hw/rtl/dwc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; depth and width come from its parameters.
module dwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dwc_ctrl.sv =====
// Controller for the deque-with-cursor block: input/output handshake sequencing.
// Depends on dwc_pkg for the command struct.
module dwc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dwc_pkg::dwc_cmd_t cmd_o
);
  import dwc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequence: accept a word, then wait for the slot read and a free output register
  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== hw/rtl/dwc_dp.sv =====
// Datapath for the deque-with-cursor block: head, count, cursor, slot store, result.
// Depends on dwc_pkg and instantiates dwc_ram for the slot store.
module dwc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dwc_pkg::dwc_cmd_t cmd_i,
  input  logic [3:0]        kind_i,
  input  dwc_pkg::item_t    item_i,
  output dwc_pkg::result_t  result_item_o,
  output logic              item_valid_o,
  output dwc_pkg::cnt_t     entry_count_o,
  output logic              push_dropped_o
);
  import dwc_pkg::*;

  op_e     op;
  idx_t    head_q, head_d;
  cnt_t    count_q, count_d;
  idx_t    cur_q, cur_d;
  logic    cur_vld_q, cur_vld_d;
  idx_t    last_slot;
  logic    empty, full;
  logic    hit, wr_ok, dropped;
  idx_t    rd_addr, wr_addr;
  item_t   rdata;

  // Captured at accept, used when the slot read returns
  logic    hit_q;
  cnt_t    cnt_pend_q;
  logic    drop_pend_q;

  // Output register
  result_t res_q;
  logic    vld_q;
  cnt_t    cnt_q;
  logic    drop_q;

  assign op        = op_e'(kind_i);
  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign last_slot = ring_add(head_q, count_q - 1'b1);

  // Decode the operation into next state and at most one slot access
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    hit       = 1'b0;
    wr_ok     = 1'b0;
    dropped   = 1'b0;
    rd_addr   = head_q;
    wr_addr   = head_q;
    case (op)
      OP_PUSH_BACK: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          wr_ok   = 1'b1;
          wr_addr = ring_add(head_q, count_q);
          count_d = count_q + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          wr_ok   = 1'b1;
          head_d  = ring_dec(head_q);
          wr_addr = ring_dec(head_q);
          count_d = count_q + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          cur_vld_d = 1'b0;
        end else begin
          if (cur_vld_q && cur_q == last_slot) begin
            cur_vld_d = 1'b0;
          end
          hit     = 1'b1;
          rd_addr = last_slot;
          count_d = count_q - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          cur_vld_d = 1'b0;
        end else begin
          if (cur_vld_q && cur_q == head_q) begin
            cur_vld_d = 1'b0;
          end
          hit     = 1'b1;
          rd_addr = head_q;
          head_d  = ring_add(head_q, CNT_W'(1));
          count_d = count_q - 1'b1;
        end
      end
      OP_START: begin
        cur_vld_d = !empty;
        cur_d     = empty ? '0 : head_q;
      end
      OP_NEXT: begin
        if (empty) begin
          cur_vld_d = 1'b0;
          cur_d     = '0;
        end else if (!cur_vld_q) begin
          cur_vld_d = 1'b1;
          cur_d     = head_q;
        end else if (cur_q == last_slot) begin
          cur_vld_d = 1'b0;
          cur_d     = '0;
        end else begin
          cur_d = ring_add(cur_q, CNT_W'(1));
        end
      end
      OP_END: begin
        cur_vld_d = !empty;
        cur_d     = empty ? '0 : last_slot;
      end
      OP_FIRST: begin
        if (!empty) begin
          hit     = 1'b1;
          rd_addr = head_q;
        end
      end
      OP_LAST: begin
        if (!empty) begin
          hit     = 1'b1;
          rd_addr = last_slot;
        end
      end
      default: begin
      end
    endcase
    // Cursor operations report the item under the updated cursor
    if (op inside {OP_START, OP_NEXT, OP_END, OP_CURRENT}) begin
      if (cur_vld_d) begin
        hit     = 1'b1;
        rd_addr = cur_d;
      end
    end
  end

  // Ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
    end else if (cmd_i.accept) begin
      head_q    <= head_d;
      count_q   <= count_d;
      cur_q     <= cur_d;
      cur_vld_q <= cur_vld_d;
    end
  end

  // Hold the result fields that do not come from the store
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hit_q       <= hit;
      cnt_pend_q  <= count_d;
      drop_pend_q <= dropped;
    end
  end

  dwc_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && wr_ok),
    .waddr_i (wr_addr),
    .wdata_i (item_i),
    .re_i    (cmd_i.accept && hit),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Output register: zero the item when nothing was read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q  <= hit_q ? RESULT_W'(rdata) : '0;
      vld_q  <= hit_q;
      cnt_q  <= cnt_pend_q;
      drop_q <= drop_pend_q;
    end
  end

  assign result_item_o  = res_q;
  assign item_valid_o   = vld_q;
  assign entry_count_o  = cnt_q;
  assign push_dropped_o = drop_q;

endmodule

// ===== tb/deque_with_cursor_unit_tb.sv =====
// Self-checking bench for deque_with_cursor_unit: a mirror of the ring, count and
// cursor predicts every result word; random stalls load both stream sides.
// Depends on dwc_pkg and the deque_with_cursor_unit RTL.
`timescale 1ns / 100ps

module deque_with_cursor_unit_tb;
  import dwc_pkg::*;

  localparam int unsigned MAX_GAP      = 19;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned SEGMENT      = 150;
  localparam int unsigned SETTLE_TICKS = 20;
  localparam int unsigned STALL_LIMIT  = 1000;

  // Result fields: result_item, item_valid (tuser), entry_count, push_dropped
  typedef struct packed {
    logic    push_dropped;
    cnt_t    entry_count;
    logic    item_valid;
    result_t result_item;
  } result_word_t;

  // Mirror of the deque contents and cursor; holds the result words still owed
  class deque_mirror;
    item_t        ring [DEPTH];
    int unsigned  head;
    int unsigned  fill;
    int unsigned  cur;
    bit           cur_ok;
    result_word_t owed_words [$];
    int unsigned  errors;

    function int unsigned tail_slot();
      return (head + fill + DEPTH - 1) % DEPTH;
    endfunction

    // Apply one accepted operation and queue the word it must produce
    function void apply_op(logic [KIND_W-1:0] kind, item_t item);
      result_word_t w;
      int unsigned  s;
      w = '0;
      case (kind)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (fill == DEPTH) begin
            w.push_dropped = 1'b1;
          end else if (kind == OP_PUSH_BACK) begin
            ring[(head + fill) % DEPTH] = item;
            fill++;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = item;
            fill++;
          end
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          if (fill == 0) begin
            cur_ok = 1'b0;
          end else begin
            s = (kind == OP_POP_BACK) ? tail_slot() : head;
            // drop the cursor when its item leaves
            if (cur_ok && cur == s) cur_ok = 1'b0;
            w.result_item = ring[s];
            w.item_valid  = 1'b1;
            if (kind == OP_POP_FRONT) head = (head + 1) % DEPTH;
            fill--;
          end
        end
        OP_START: begin
          cur_ok = (fill != 0);
          cur    = cur_ok ? head : 0;
        end
        OP_NEXT: begin
          if (fill == 0) begin
            cur_ok = 1'b0;
            cur    = 0;
          end else if (!cur_ok) begin
            cur_ok = 1'b1;
            cur    = head;
          end else if (cur == tail_slot()) begin
            cur_ok = 1'b0;
            cur    = 0;
          end else begin
            cur = (cur + 1) % DEPTH;
          end
        end
        OP_END: begin
          cur_ok = (fill != 0);
          cur    = cur_ok ? tail_slot() : 0;
        end
        OP_FIRST, OP_LAST: begin
          if (fill != 0) begin
            w.result_item = ring[(kind == OP_FIRST) ? head : tail_slot()];
            w.item_valid  = 1'b1;
          end
        end
        default: ;
      endcase
      // cursor moves and current report the item under the cursor
      if (kind >= OP_START && kind <= OP_CURRENT && cur_ok) begin
        w.result_item = ring[cur];
        w.item_valid  = 1'b1;
      end
      w.entry_count = cnt_t'(fill);
      owed_words.push_back(w);
    endfunction

    // Compare one result word against the oldest owed word
    function void compare_word(logic [M_TDATA_W-1:0] raw, logic user);
      result_word_t got;
      result_word_t want;
      got.result_item  = raw[RESULT_W-1:0];
      got.entry_count  = raw[RESULT_W +: CNT_W];
      got.push_dropped = raw[RESULT_W + CNT_W];
      got.item_valid   = user;
      if (owed_words.size() == 0) begin
        $error("result word %h arrived with nothing owed", raw);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      if (got.result_item !== want.result_item) begin
        $error("result_item: expected %h, got %h", want.result_item, got.result_item);
        errors++;
      end
      if (got.item_valid !== want.item_valid) begin
        $error("item_valid: expected %b, got %b", want.item_valid, got.item_valid);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.push_dropped !== want.push_dropped) begin
        $error("push_dropped: expected %b, got %b", want.push_dropped, got.push_dropped);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [KIND_W-1:0]    s_axis_tuser;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 m_axis_tuser;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  deque_mirror mirror = new;
  bit          s_idle_on;
  bit          m_idle_on;
  int unsigned quiet_cycles;

  deque_with_cursor_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Send one word after a random gap; note it in the mirror once taken
  task automatic send_op(logic [KIND_W-1:0] kind, item_t item);
    int unsigned gap;
    gap = s_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= S_TDATA_W'(item);
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.apply_op(kind, item);
  endtask

  // Hold the sender off until every owed word has come back
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (mirror.owed_words.size() != 0);
  endtask

  // Result side: random stall before each word, then check it
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = m_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      mirror.compare_word(m_axis_tdata, m_axis_tuser);
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Stimulus: directed corner cases, then random segments of varying push bias
  initial begin
    logic [KIND_W-1:0] kind;
    item_t             item;
    int unsigned       push_pct;
    int unsigned       roll;
    int unsigned       pick;
    bit                front;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= '0;
    s_axis_tdata  <= '0;
    s_idle_on     = 1'b1;
    m_idle_on     = 1'b1;
    push_pct      = 50;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // everything on an empty deque
    send_op(OP_POP_BACK, $urandom);
    send_op(OP_POP_FRONT, $urandom);
    send_op(OP_START, $urandom);
    send_op(OP_NEXT, $urandom);
    send_op(OP_END, $urandom);
    send_op(OP_CURRENT, $urandom);
    send_op(OP_FIRST, $urandom);
    send_op(OP_LAST, $urandom);
    // extreme handles at both ends, then a full cursor walk past the end
    send_op(OP_PUSH_BACK, '1);
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_PUSH_BACK, 32'hA5C3_3C5A);
    send_op(OP_FIRST, $urandom);
    send_op(OP_LAST, $urandom);
    send_op(OP_NEXT, $urandom);
    send_op(OP_NEXT, $urandom);
    send_op(OP_NEXT, $urandom);
    send_op(OP_NEXT, $urandom);
    send_op(OP_CURRENT, $urandom);
    // pop the item under the cursor from each end
    send_op(OP_END, $urandom);
    send_op(OP_POP_BACK, $urandom);
    send_op(OP_CURRENT, $urandom);
    send_op(OP_START, $urandom);
    send_op(OP_POP_FRONT, $urandom);
    // unused kinds do nothing
    send_op(KIND_W'(OP_LAST) + 1'b1, $urandom);
    send_op('1, $urandom);
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT == 0) begin
        pick = $urandom_range(0, 2);
        push_pct  = (pick == 0) ? 95 : (pick == 1) ? 50 : 5;
        s_idle_on = ($urandom_range(0, 3) != 0);
        m_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        kind = KIND_W'($urandom_range(int'(OP_LAST) + 1, (1 << KIND_W) - 1));
      end else if (roll < 55) begin
        front = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < push_pct) begin
          kind = front ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
          kind = front ? OP_POP_FRONT : OP_POP_BACK;
        end
      end else begin
        // cursor and read operations, next weighted up to walk far
        pick = $urandom_range(int'(OP_START), int'(OP_LAST) + 2);
        kind = (pick > int'(OP_LAST)) ? OP_NEXT : KIND_W'(pick);
      end
      if ($urandom_range(0, 15) == 0) begin
        item = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        item = $urandom;
      end
      send_op(kind, item);
    end

    hold_until_drained();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
